// ===== rtl/qpd_pkg.sv =====
// Shared constants, types and the arctangent table of the quaternion PD torque block.
package qpd_pkg;

    localparam int QW       = 16;             // quaternion, omega and gain width
    localparam int EM_W     = 33;             // magnitude of one error vector part
    localparam int W_W      = 29;             // clamped error w, Q.28, up to 1.0
    localparam int V_W      = 57;             // 1 - w^2 in Q.56
    localparam int ROOT_W   = 29;             // sine in Q.28
    localparam int CORD_N   = 17;             // CORDIC iterations
    localparam int CORD_W   = 32;             // CORDIC x/y width
    localparam int ANG_W    = 18;             // signed half angle accumulator
    localparam int QUO_W    = 18;             // axis quotient bits
    localparam int NUM_W    = EM_W + 16;      // dividend |e| * 2^16
    localparam int AXIS_W   = 18;
    localparam int TQ_W     = 32;

    localparam logic [W_W-1:0]    ONE_Q28     = W_W'(268435456);
    localparam logic [ROOT_W-1:0] SMALL_SINE  = ROOT_W'(16384);
    localparam logic [16:0]       HALF_PI_Q16 = 17'd102944;
    localparam logic [QUO_W-1:0]  AXIS_MAX    = QUO_W'(65536);

    // configuration register indexes
    localparam logic [0:0] REG_PROP_GAIN = 1'b0;
    localparam logic [0:0] REG_DAMP_GAIN = 1'b1;

    typedef struct packed {
        logic                      active;
        logic [2:0][QW-1:0]        om;
        logic [2:0]                e_neg;
        logic [2:0][EM_W-1:0]      e_mag;
        logic [W_W-1:0]            w;
    } sq_side_t;

    typedef struct packed {
        logic                      active;
        logic [2:0][QW-1:0]        om;
        logic [2:0]                e_neg;
        logic                      small_sine;
    } ad_side_t;

    // atan(2^-i) in Q.16 radians
    function automatic logic [16:0] atan_tab(input logic [4:0] idx);
        logic [16:0] r;
        case (idx)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30386;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/qpd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qpd_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [qpd_pkg::V_W-1:0]       v_in,
    input  qpd_pkg::sq_side_t             side_in,
    output logic                          out_vld,
    output logic [qpd_pkg::ROOT_W-1:0]    s_out,
    output qpd_pkg::sq_side_t             side_out
);

    localparam int N  = qpd_pkg::ROOT_W;
    localparam int VW = qpd_pkg::V_W;
    localparam int TW = VW + 2;

    logic [VW-1:0]          rem_reg  [N-1];
    logic [N-1:0]           root_reg [N];
    qpd_pkg::sq_side_t      side_reg [N];
    logic                   vld_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int B = N - 1 - k;
        logic [VW-1:0]     rem_p;
        logic [N-1:0]      root_p;
        qpd_pkg::sq_side_t side_p;
        logic              vld_p;
        logic [TW-1:0]     trial;
        logic              take;
        logic [N-1:0]      root_next;

        if (k == 0) begin : g_first
            assign rem_p  = v_in;
            assign root_p = '0;
            assign side_p = side_in;
            assign vld_p  = in_vld;
        end else begin : g_rest
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign side_p = side_reg[k-1];
            assign vld_p  = vld_reg[k-1];
        end

        // (root + 2^B)^2 - root^2
        assign trial     = (TW'(root_p) << (B + 1)) + (TW'(1) << (2 * B));
        assign take      = TW'(rem_p) >= trial;
        assign root_next = take ? (root_p | (N'(1) << B)) : root_p;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= root_next;
                side_reg[k] <= side_p;
            end
        end

        if (k < N - 1) begin : g_rem
            logic [VW-1:0] rem_next;
            assign rem_next = take ? (rem_p - trial[VW-1:0]) : rem_p;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    end

    assign out_vld  = vld_reg[N-1];
    assign s_out    = root_reg[N-1];
    assign side_out = side_reg[N-1];

endmodule

// ===== rtl/qpd_atan_div.sv =====
// Pipelined CORDIC half angle and three restoring dividers for the rotation axis.
module qpd_atan_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [qpd_pkg::W_W-1:0]              w_in,
    input  logic [qpd_pkg::ROOT_W-1:0]           s_in,
    input  logic [2:0][qpd_pkg::EM_W-1:0]        e_mag_in,
    input  qpd_pkg::ad_side_t                    side_in,
    output logic                                 out_vld,
    output logic [16:0]                          half_ang,
    output logic [2:0][qpd_pkg::QUO_W-1:0]       quo,
    output logic [2:0]                           quo_ovf,
    output qpd_pkg::ad_side_t                    side_out
);

    localparam int CN = qpd_pkg::CORD_N;
    localparam int ST = qpd_pkg::QUO_W + 1;      // load stage + one stage per quotient bit
    localparam int CW = qpd_pkg::CORD_W;
    localparam int AW = qpd_pkg::ANG_W;
    localparam int NW = qpd_pkg::NUM_W;
    localparam int RW = qpd_pkg::ROOT_W;
    localparam int QB = qpd_pkg::QUO_W;

    logic signed [CW-1:0]   x_reg    [ST-1];
    logic signed [CW-1:0]   y_reg    [ST-1];
    logic signed [AW-1:0]   z_reg    [ST];
    logic [2:0][NW-1:0]     rem_reg  [ST-1];
    logic [2:0][QB-1:0]     q_reg    [ST];
    logic [2:0]             ovf_reg  [ST];
    logic [RW-1:0]          s_reg    [ST-1];
    qpd_pkg::ad_side_t      side_reg [ST];
    logic                   vld_reg  [ST];

    for (genvar k = 0; k < ST; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= (k == 0) ? in_vld : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end

        if (k == 0) begin : g_load
            logic [2:0] ovf_next;
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    ovf_next[j] = {e_mag_in[j], 16'd0} >= {2'd0, s_in, 18'd0};
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[0]    <= CW'(w_in);
                    y_reg[0]    <= CW'(s_in);
                    z_reg[0]    <= '0;
                    for (int j = 0; j < 3; j++) begin
                        rem_reg[0][j] <= {e_mag_in[j], 16'd0};
                    end
                    q_reg[0]    <= '0;
                    ovf_reg[0]  <= ovf_next;
                    s_reg[0]    <= s_in;
                    side_reg[0] <= side_in;
                end
            end
        end else begin : g_step
            localparam int B = ST - 1 - k;          // quotient bit of this stage
            logic [2:0]         take;
            logic [2:0][QB-1:0] q_next;
            logic [NW-1:0]      dsh;

            assign dsh = NW'(s_reg[k-1]) << B;

            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    take[j]   = rem_reg[k-1][j] >= dsh;
                    q_next[j] = take[j] ? (q_reg[k-1][j] | (QB'(1) << B)) : q_reg[k-1][j];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[k]    <= q_next;
                    ovf_reg[k]  <= ovf_reg[k-1];
                    side_reg[k] <= side_reg[k-1];
                end
            end

            if (k < ST - 1) begin : g_mid
                localparam int I = k - 1;           // CORDIC iteration of this stage
                logic [2:0][NW-1:0]   rem_next;
                logic signed [CW-1:0] xs, ys, x_next, y_next;
                logic signed [AW-1:0] z_next, tab;

                assign xs  = x_reg[k-1] >>> I;
                assign ys  = y_reg[k-1] >>> I;
                assign tab = AW'(qpd_pkg::atan_tab(5'(I)));

                always_comb begin
                    for (int j = 0; j < 3; j++) begin
                        rem_next[j] = take[j] ? (rem_reg[k-1][j] - dsh) : rem_reg[k-1][j];
                    end
                    if (y_reg[k-1] > 0) begin
                        x_next = x_reg[k-1] + ys;
                        y_next = y_reg[k-1] - xs;
                        z_next = z_reg[k-1] + tab;
                    end else begin
                        x_next = x_reg[k-1] - ys;
                        y_next = y_reg[k-1] + xs;
                        z_next = z_reg[k-1] - tab;
                    end
                end

                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k] <= rem_next;
                        x_reg[k]   <= x_next;
                        y_reg[k]   <= y_next;
                        z_reg[k]   <= z_next;
                        s_reg[k]   <= s_reg[k-1];
                    end
                end
            end else begin : g_last
                logic signed [AW-1:0] z_next;
                always_comb begin
                    if (z_reg[k-1] < 0) begin
                        z_next = '0;
                    end else if (z_reg[k-1] > $signed({1'b0, qpd_pkg::HALF_PI_Q16})) begin
                        z_next = $signed({1'b0, qpd_pkg::HALF_PI_Q16});
                    end else begin
                        z_next = z_reg[k-1];
                    end
                end
                always_ff @(posedge aclk) begin
                    if (en) begin
                        z_reg[k] <= z_next;
                    end
                end
            end
        end
    end

    assign out_vld  = vld_reg[ST-1];
    assign half_ang = z_reg[ST-1][16:0];
    assign quo      = q_reg[ST-1];
    assign quo_ovf  = ovf_reg[ST-1];
    assign side_out = side_reg[ST-1];

endmodule

// ===== rtl/quaternion_pd_torque.sv =====
// Quaternion PD attitude torque: top level with the product, sum, gain and output stages.
//
// One item per body: target and current orientation (Q1.14), angular velocity (Q8.8)
// and an active flag come in on the s_ stream; one item with the three Q16.16 torque
// parts, saturated to 32 bits, leaves on the m_ stream for every item taken.
// prop_gain (index 0) and damp_gain (index 1), both reset to zero, are written on the cfg_
// port; the user must write them only while no item is in flight; the block does not enforce it.
// From acceptance to m_tvalid an item passes 5 stages of products and error
// quaternion set-up, 29 square-root stages (one sine bit each), 19 stages of
// CORDIC half angle running beside the axis dividers (one quotient bit each), and
// 4 stages of gain multiplies, rounding and saturation.
// Throughput is one item per cycle. All stages advance together; when m_tvalid is
// high and m_tready is low the whole pipe holds and s_tready drops, so no item is
// lost or repeated. Synchronous active-low reset clears all valid bits and the gains.
module quaternion_pd_torque (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // target_active, goal_w, goal_x, goal_y, goal_z, cur_w, cur_x, cur_y, cur_z,
    // omega_x, omega_y, omega_z; zero pad
    input  logic [183:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // torque_x, torque_y, torque_z
    output logic [95:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam int QW = qpd_pkg::QW;

    logic [QW-1:0] prop_gain_reg, damp_gain_reg;
    logic          adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg <= '0;
            damp_gain_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                qpd_pkg::REG_PROP_GAIN: prop_gain_reg <= cfg_wdata;
                qpd_pkg::REG_DAMP_GAIN: damp_gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- stage 1: sixteen quaternion products
    logic signed [15:0] tw, tx, ty, tz, cw, cx, cy, cz;
    logic signed [31:0] prod_next [16];
    logic signed [31:0] prod_reg  [16];
    logic [2:0][15:0]   om_in, om1_reg, om2_reg;
    logic               vld1_reg, act1_reg;

    assign tw = $signed(s_tdata[16:1]);
    assign tx = $signed(s_tdata[32:17]);
    assign ty = $signed(s_tdata[48:33]);
    assign tz = $signed(s_tdata[64:49]);
    assign cw = $signed(s_tdata[80:65]);
    assign cx = $signed(s_tdata[96:81]);
    assign cy = $signed(s_tdata[112:97]);
    assign cz = $signed(s_tdata[128:113]);
    assign om_in[0] = s_tdata[144:129];
    assign om_in[1] = s_tdata[160:145];
    assign om_in[2] = s_tdata[176:161];

    always_comb begin
        prod_next[0]  = tw * cw;  prod_next[1]  = tx * cx;
        prod_next[2]  = ty * cy;  prod_next[3]  = tz * cz;
        prod_next[4]  = tw * cx;  prod_next[5]  = tx * cw;
        prod_next[6]  = ty * cz;  prod_next[7]  = tz * cy;
        prod_next[8]  = tw * cy;  prod_next[9]  = tx * cz;
        prod_next[10] = ty * cw;  prod_next[11] = tz * cx;
        prod_next[12] = tw * cz;  prod_next[13] = tx * cy;
        prod_next[14] = ty * cx;  prod_next[15] = tz * cw;
    end

    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            act1_reg <= s_tdata[0];
            om1_reg  <= om_in;
        end
    end

    // ---- stage 2: error quaternion e = goal * conj(cur)
    logic signed [33:0] ew_reg;
    logic signed [33:0] e_reg [3];
    logic               vld2_reg, act2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (adv) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ew_reg   <= 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2])
                      + 34'(prod_reg[3]);
            e_reg[0] <= 34'(prod_reg[5]) - 34'(prod_reg[4]) - 34'(prod_reg[6])
                      + 34'(prod_reg[7]);
            e_reg[1] <= 34'(prod_reg[9]) - 34'(prod_reg[8]) + 34'(prod_reg[10])
                      - 34'(prod_reg[11]);
            e_reg[2] <= 34'(prod_reg[14]) - 34'(prod_reg[12]) - 34'(prod_reg[13])
                      + 34'(prod_reg[15]);
            act2_reg <= act1_reg;
            om2_reg  <= om1_reg;
        end
    end

    // ---- stage 3: fold to w >= 0, clamp w, split xyz into sign and magnitude
    qpd_pkg::sq_side_t  side3_next, side3_reg, side4_reg, side5_reg;
    logic signed [33:0] aw;
    logic signed [33:0] ae [3];
    logic               vld3_reg, vld4_reg, vld5_reg;

    always_comb begin
        aw = ew_reg[33] ? -ew_reg : ew_reg;
        side3_next.active = act2_reg;
        side3_next.om     = om2_reg;
        side3_next.w      = (aw > 34'sd268435456) ? qpd_pkg::ONE_Q28 : aw[28:0];
        for (int j = 0; j < 3; j++) begin
            ae[j]                = e_reg[j][33] ? -e_reg[j] : e_reg[j];
            side3_next.e_mag[j]  = ae[j][32:0];
            side3_next.e_neg[j]  = e_reg[j][33] ^ ew_reg[33];
        end
    end

    // ---- stage 4: w^2 as three narrow partial products
    logic [27:0] hh_reg;
    logic [28:0] hl_reg;
    logic [29:0] ll_reg;
    logic [13:0] wh;
    logic [14:0] wl;

    assign wh = side3_reg.w[28:15];
    assign wl = side3_reg.w[14:0];

    // ---- stage 5: v = 1 - w^2 in Q.56
    logic [57:0]            sq_sum;
    logic [qpd_pkg::V_W-1:0] v_reg;

    assign sq_sum = (58'(hh_reg) << 30) + (58'(hl_reg) << 16) + 58'(ll_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (adv) begin
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side3_reg <= side3_next;
            hh_reg    <= wh * wh;
            hl_reg    <= wh * wl;
            ll_reg    <= wl * wl;
            side4_reg <= side3_reg;
            v_reg     <= qpd_pkg::V_W'((58'd1 << 56) - sq_sum);
            side5_reg <= side4_reg;
        end
    end

    // ---- sine = floor(sqrt(v))
    logic                          sq_vld;
    logic [qpd_pkg::ROOT_W-1:0]    sq_s;
    qpd_pkg::sq_side_t             sq_side;

    qpd_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (vld5_reg),
        .v_in     (v_reg),
        .side_in  (side5_reg),
        .out_vld  (sq_vld),
        .s_out    (sq_s),
        .side_out (sq_side)
    );

    // ---- half angle and axis quotients
    qpd_pkg::ad_side_t              ad_in, ad_side;
    logic                           ad_vld;
    logic [16:0]                    ad_z;
    logic [2:0][qpd_pkg::QUO_W-1:0] ad_q;
    logic [2:0]                     ad_ovf;

    assign ad_in.active     = sq_side.active;
    assign ad_in.om         = sq_side.om;
    assign ad_in.e_neg      = sq_side.e_neg;
    assign ad_in.small_sine = sq_s <= qpd_pkg::SMALL_SINE;

    qpd_atan_div u_atan_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (sq_vld),
        .w_in     (sq_side.w),
        .s_in     (sq_s),
        .e_mag_in (sq_side.e_mag),
        .side_in  (ad_in),
        .out_vld  (ad_vld),
        .half_ang (ad_z),
        .quo      (ad_q),
        .quo_ovf  (ad_ovf),
        .side_out (ad_side)
    );

    // ---- stage A: clamp and sign the axis, angle = 2 * half angle
    logic signed [17:0] axis_next [3];
    logic signed [17:0] axis_reg  [3];
    logic [17:0]        mag [3];
    logic [17:0]        angle_reg;
    logic [2:0][15:0]   oma_reg;
    logic               vlda_reg, vldb_reg, vldc_reg;
    logic               acta_reg, actb_reg, actc_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            mag[j] = (ad_ovf[j] || ad_q[j] > qpd_pkg::AXIS_MAX) ? qpd_pkg::AXIS_MAX : ad_q[j];
            if (ad_side.small_sine) begin
                axis_next[j] = '0;
            end else begin
                axis_next[j] = ad_side.e_neg[j] ? $signed(-mag[j]) : $signed(mag[j]);
            end
        end
    end

    // ---- stage B: axis * angle, omega * damp_gain
    logic signed [36:0] pa_reg [3];
    logic signed [32:0] d_reg  [3];
    logic signed [32:0] dc_reg [3];
    // ---- stage C: * prop_gain
    logic signed [53:0] pp_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlda_reg <= 1'b0;
            vldb_reg <= 1'b0;
            vldc_reg <= 1'b0;
        end else if (adv) begin
            vlda_reg <= ad_vld;
            vldb_reg <= vlda_reg;
            vldc_reg <= vldb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            axis_reg  <= axis_next;
            angle_reg <= {ad_z, 1'b0};
            oma_reg   <= ad_side.om;
            acta_reg  <= ad_side.active;
            for (int j = 0; j < 3; j++) begin
                pa_reg[j] <= axis_reg[j] * $signed({1'b0, angle_reg});
                d_reg[j]  <= $signed(oma_reg[j]) * $signed({1'b0, damp_gain_reg});
                pp_reg[j] <= pa_reg[j] * $signed({1'b0, prop_gain_reg});
                dc_reg[j] <= d_reg[j];
            end
            actb_reg  <= acta_reg;
            actc_reg  <= actb_reg;
        end
    end

    // ---- output stage: round P to Q.16, subtract D, saturate; zero for inactive items
    logic signed [54:0] rnd  [3];
    logic signed [30:0] pq   [3];
    logic signed [34:0] diff [3];
    logic [95:0]        tdata_next, m_tdata_reg;
    logic               out_vld_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            rnd[j]  = 55'(pp_reg[j]) + 55'sd8388608;
            pq[j]   = rnd[j][54:24];
            diff[j] = 35'(pq[j]) - 35'(dc_reg[j]);
            if (!actc_reg) begin
                tdata_next[32*j +: 32] = '0;
            end else if (diff[j] > 35'sd2147483647) begin
                tdata_next[32*j +: 32] = 32'h7FFF_FFFF;
            end else if (diff[j] < -35'sd2147483648) begin
                tdata_next[32*j +: 32] = 32'h8000_0000;
            end else begin
                tdata_next[32*j +: 32] = diff[j][31:0];
            end
        end
    end

    assign adv = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vldc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb_quaternion_pd_torque.sv =====
// Self-checking testbench for the quaternion PD torque block.
`timescale 1ns / 1ps

class torque_scoreboard;
    bit [15:0] kp;
    bit [15:0] kd;
    logic [95:0] pending[$];
    int errors;

    function new();
        kp = 0;
        kd = 0;
        errors = 0;
    endfunction

    static function longint fshr(longint v, int n);
        return v >>> n;
    endfunction

    static function longint root64(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    static function longint half_angle(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        longint tab[17];
        tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2, 1};
        z = 0;
        for (int i = 0; i < 17; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + tab[i];
            end else begin
                x = x - ys; y = y + xs; z = z - tab[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 102944) z = 102944;
        return z;
    endfunction

    function logic [95:0] torque_of(logic [183:0] d);
        longint tw, tx, ty, tz, cw, cx, cy, cz;
        longint ew, w, s, angle, axis, p, t;
        longint e[3];
        longint om[3];
        logic [95:0] r;
        r = '0;
        if (!d[0]) return r;
        tw = $signed(d[16:1]);   tx = $signed(d[32:17]);
        ty = $signed(d[48:33]);  tz = $signed(d[64:49]);
        cw = $signed(d[80:65]);  cx = $signed(d[96:81]);
        cy = $signed(d[112:97]); cz = $signed(d[128:113]);
        om[0] = $signed(d[144:129]);
        om[1] = $signed(d[160:145]);
        om[2] = $signed(d[176:161]);
        ew   = tw * cw + tx * cx + ty * cy + tz * cz;
        e[0] = -tw * cx + tx * cw - ty * cz + tz * cy;
        e[1] = -tw * cy + tx * cz + ty * cw - tz * cx;
        e[2] = -tw * cz - tx * cy + ty * cx + tz * cw;
        if (ew < 0) begin
            ew = -ew;
            foreach (e[k]) e[k] = -e[k];
        end
        w = (ew > (64'sd1 <<< 28)) ? (64'sd1 <<< 28) : ew;
        s = root64((64'sd1 <<< 56) - w * w);
        angle = 2 * half_angle(w, s);
        for (int k = 0; k < 3; k++) begin
            axis = 0;
            if (s > 16384) begin
                axis = (e[k] * 65536) / s;
                if (axis > 65536) axis = 65536;
                if (axis < -65536) axis = -65536;
            end
            p = fshr(axis * angle * longint'(kp) + (64'sd1 <<< 23), 24);
            t = p - om[k] * longint'(kd);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            r[k*32 +: 32] = t[31:0];
        end
        return r;
    endfunction

    function void note_item(logic [183:0] d);
        pending.push_back(torque_of(d));
    endfunction

    function void check_result(logic [95:0] got);
        logic [95:0] want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        for (int k = 0; k < 3; k++)
            if (want[k*32 +: 32] !== got[k*32 +: 32]) begin
                $display("%0t: torque[%0d] expected %h actual %h", $time, k,
                         want[k*32 +: 32], got[k*32 +: 32]);
                errors++;
            end
    endfunction
endclass

module tb_quaternion_pd_torque;

    localparam int LATENCY = 57;
    localparam longint CYCLE_LIMIT = 400000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;
    logic         cfg_we = 0;
    logic [0:0]   cfg_index = qpd_pkg::REG_PROP_GAIN;
    logic [15:0]  cfg_wdata = '0;

    torque_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    bit recv_hold = 0;
    longint cycles = 0;

    quaternion_pd_torque DUT (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check and decide tready for the next edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (!aresetn || recv_hold) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic set_reg(logic [0:0] idx, logic [15:0] v);
        if (idx == qpd_pkg::REG_PROP_GAIN) sb.kp = v; else sb.kd = v;
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    // offer one item; valid stays high until accepted
    task automatic send_item(logic [183:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(d);
    endtask

    function automatic logic [15:0] quat_part();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(0);
            3: return 16'($urandom());
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [183:0] pack_item(bit act, logic [15:0] q[8],
                                               logic [15:0] om[3]);
        logic [183:0] d;
        d = '0;
        d[0] = act;
        for (int i = 0; i < 8; i++) d[1 + 16*i +: 16] = q[i];
        for (int i = 0; i < 3; i++) d[129 + 16*i +: 16] = om[i];
        return d;
    endfunction

    function automatic logic [183:0] rand_item();
        logic [15:0] q[8];
        logic [15:0] om[3];
        for (int i = 0; i < 8; i++) q[i] = quat_part();
        // near-identical orientations hit the small-sine path
        if ($urandom_range(7) == 0)
            for (int i = 0; i < 4; i++)
                q[4+i] = q[i] + 16'($signed($urandom_range(4)) - 2);
        for (int i = 0; i < 3; i++) om[i] = 16'($urandom());
        return pack_item($urandom_range(9) != 0, q, om);
    endfunction

    task automatic directed_items();
        logic [15:0] q[8];
        logic [15:0] om[3];
        logic [15:0] ext[4];
        ext = '{16'sh4000, 16'shC000, 16'h0000, 16'hFFFF};
        om = '{16'h7FFF, 16'h8000, 16'h0001};
        q = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0};
        send_item(pack_item(1, q, om));          // identical: zero sine
        send_item(pack_item(0, q, om));          // inactive
        q = '{16'sh4000, 0, 0, 0, 16'shC000, 0, 0, 0};
        send_item(pack_item(1, q, om));          // negated w flips
        q = '{0, 16'sh4000, 0, 0, 16'sh4000, 0, 0, 0};
        send_item(pack_item(1, q, om));          // half turn about x
        q = '{0, 0, 16'sh4000, 0, 16'sh4000, 0, 0, 0};
        send_item(pack_item(1, q, om));
        q = '{0, 0, 0, 16'sh4000, 16'sh4000, 0, 0, 0};
        send_item(pack_item(1, q, om));
        for (int i = 0; i < 4; i++) begin
            q = '{ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4],
                  ext[(i+3)%4], ext[i], ext[(i+1)%4], ext[(i+2)%4]};
            send_item(pack_item(1, q, om));
        end
        q = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
        send_item(pack_item(1, q, '{16'h8000, 16'h8000, 16'h8000}));
        send_item(pack_item(1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                            '{16'hFFFF, 16'hFFFF, 16'hFFFF}));
        send_item(pack_item(1, '{16'sh2D41, 16'sh2D41, 0, 0, 16'sh4000, 0, 0, 0},
                            '{0, 0, 0}));
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_item(rand_item());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // gains at reset value of zero
        directed_items();
        drain();
        set_reg(qpd_pkg::REG_PROP_GAIN, 16'hFFFF);
        set_reg(qpd_pkg::REG_DAMP_GAIN, 16'hFFFF);
        directed_items();
        drain();
        set_reg(qpd_pkg::REG_PROP_GAIN, 16'h0100);
        set_reg(qpd_pkg::REG_DAMP_GAIN, 16'h0080);
        directed_items();

        send_idle = 32; recv_idle = 67;
        random_phase(500);
        drain();
        set_reg(qpd_pkg::REG_PROP_GAIN, 16'($urandom()));
        set_reg(qpd_pkg::REG_DAMP_GAIN, 16'($urandom()));

        send_idle = 67; recv_idle = 32;
        random_phase(500);
        // sender pauses here until everything is out
        drain();
        set_reg(qpd_pkg::REG_PROP_GAIN, 16'h0001);
        set_reg(qpd_pkg::REG_DAMP_GAIN, 16'h0000);

        send_idle = 0; recv_idle = 0;
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge aclk);
                recv_hold = 0;
            end
            random_phase(400);
        join
        drain();
        set_reg(qpd_pkg::REG_PROP_GAIN, 16'($urandom()));
        set_reg(qpd_pkg::REG_DAMP_GAIN, 16'($urandom()));
        random_phase(300);
        drain();

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
